// File: rtl/sdf_pkg.sv
// ---------------------------------------------------------------------------
// sdf_pkg
// Shared widths, constants, codes and types of the ray march hit test.
// ---------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // Fixed point format of positions and distances
  localparam int FRAC_BITS = 16;
  // Hard cap on march steps
  localparam int MAX_STEPS = 63;

  // Field widths
  localparam int POS_W      = 32;
  localparam int DIR_W      = 18;
  localparam int DIR_FRAC   = 16;
  localparam int SIZE_W     = 31;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int MUL_W  = 33;           // signed multiplier operands
  localparam int PROD_W = 2 * MUL_W;    // registered product
  localparam int RAD_W  = 64;           // sum of squares
  localparam int ROOT_W = RAD_W / 2;
  localparam int DIFF_W = 35;           // p - c with offset center
  localparam int COMP_W = 34;           // component magnitudes
  localparam int LEN_W  = ROOT_W + 4;   // length after coarse rescale
  localparam int STEP_PROD_W = PROD_W - DIR_FRAC;

  // Center offsets of the sphere and of the cutting box, rounded
  localparam logic [POS_W-1:0] OFF_SPH = POS_W'(((17 << FRAC_BITS) + 5) / 10);
  localparam logic [POS_W-1:0] OFF_CUT = POS_W'(((24 << FRAC_BITS) + 5) / 10);

  // Distance saturation bound
  localparam logic signed [POS_W-1:0] DIST_MAX = {1'b0, {(POS_W-1){1'b1}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CZ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 3'd6;

  // Register resets
  localparam logic [SIZE_W-1:0] SIZE_RST   = 31'd65536;
  localparam logic [SIZE_W-1:0] HIT_RST    = 31'd3277;
  localparam logic [SIZE_W-1:0] ESCAPE_RST = 31'd3276800;
  localparam logic [STEP_W-1:0] STEPS_RST  = 6'd15;

  // Primitive codes
  localparam logic [1:0] PRIM_BOX = 2'd0;
  localparam logic [1:0] PRIM_SPH = 2'd1;
  localparam logic [1:0] PRIM_CUT = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_COMP,
    S_PRIM,
    S_MUL,
    S_ACC,
    S_SQS,
    S_SQRT,
    S_STORE,
    S_DECIDE,
    S_AMUL,
    S_AADD,
    S_DONE
  } state_t;

  // Square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

// File: rtl/sdf_ray_if.sv
// ---------------------------------------------------------------------------
// sdf_ray_if
// Ray request channel: origin and direction with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdf_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

`default_nettype wire

// File: rtl/sdf_hit_if.sv
// ---------------------------------------------------------------------------
// sdf_hit_if
// Result channel: one hit flag per ray with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdf_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// File: rtl/sdf_mul.sv
// ---------------------------------------------------------------------------
// sdf_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_mul (
  input  wire logic                                clk,
  input  wire logic signed [sdf_pkg::MUL_W-1:0]    a,
  input  wire logic signed [sdf_pkg::MUL_W-1:0]    b,
  output logic signed      [sdf_pkg::PROD_W-1:0]   prod
);
  import sdf_pkg::*;

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// File: rtl/sdf_sqrt.sv
// ---------------------------------------------------------------------------
// sdf_sqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [sdf_pkg::RAD_W-1:0]     radicand,
  output logic      [sdf_pkg::ROOT_W-1:0]    root,
  output sdf_pkg::sqrt_stat_t                stat
);
  import sdf_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      rad  <= rad << 2;
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/sdf_ray_march_hit_test.sv
// ---------------------------------------------------------------------------
// sdf_ray_march_hit_test
// Sphere-traced hit test of one ray against a box/sphere/cut-box scene.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  ray     | in  | valid / ready | origin_x/y/z (Q16.16), dir_x/y/z (Q1.16)
//  res     | out | valid / ready | hit
//  cfg     | in  | cfg_we        | cfg_idx, cfg_wdata
//
//  Each march step is a check state, three primitives (each: three component
//  states, a setup state, a multiply and an accumulate state per axis, a start
//  state, the bit-serial square root and a store; a box that contains the
//  point skips the multiplies and the root), a decide state and a position
//  advance of one multiply and one add state per axis. The square root unit
//  dominates the time a ray keeps the block busy. Synchronous reset loads the
//  register defaults.
//  One ray at a time; the finished flag waits in the output register while
//  the next ray is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_ray_march_hit_test (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [sdf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  sdf_ray_if.sink                               ray,
  sdf_hit_if.source                             res
);
  import sdf_pkg::*;

  // Configuration
  logic signed [POS_W-1:0]  cx, cy, cz;
  logic        [SIZE_W-1:0] r_size, hit_dist, esc_dist;
  logic        [STEP_W-1:0] steps;

  // March state
  state_t state, state_next;
  logic signed [POS_W-1:0]       p [3];
  logic signed [DIR_W-1:0]       dir [3];
  logic        [2:0][COMP_W-1:0] comp;
  logic signed [POS_W-1:0]       prim_dist [3];
  logic        [1:0]             axis;
  logic        [1:0]             prim;
  logic        [STEP_W-1:0]      step_cnt;
  logic signed [DIFF_W-1:0]      dmax;
  logic                          coarse;
  logic        [RAD_W-1:0]       acc;
  logic        [LEN_W-1:0]       len_r;
  logic signed [POS_W-1:0]       scene_r;
  logic                          hit_r;
  logic                          out_valid, out_hit;

  // Shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     sqrt_start;
  logic [ROOT_W-1:0]        root;
  sqrt_stat_t               sq_stat;

  sdf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  sdf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(acc),
    .root(root), .stat(sq_stat)
  );

  // Step limit
  logic [STEP_W-1:0] n_lim;
  always_comb begin
    n_lim = (int'(steps) > MAX_STEPS) ? STEP_W'(MAX_STEPS) : steps;
  end

  // Per-axis component: |p - c| and box excess
  logic signed [DIFF_W-1:0] c_sel, diff, dbox;
  logic        [COMP_W-1:0] mag, comp_val;
  logic        [POS_W:0]    h_sel;
  logic        [POS_W-1:0]  z_off;
  always_comb begin
    case (prim)
      PRIM_SPH: z_off = OFF_SPH;
      PRIM_CUT: z_off = OFF_CUT;
      default:  z_off = '0;
    endcase
    case (axis)
      2'd0:    c_sel = DIFF_W'(cx);
      2'd1:    c_sel = DIFF_W'(cy);
      default: c_sel = DIFF_W'(cz) + $signed({3'b0, z_off});
    endcase
    diff = DIFF_W'(p[axis]) - c_sel;
    mag  = diff[DIFF_W-1] ? COMP_W'(-diff) : diff[COMP_W-1:0];
    if (prim == PRIM_CUT) begin
      h_sel = (axis == 2'd2) ? {3'b0, r_size[SIZE_W-1:1]} : {1'b0, r_size, 1'b0};
    end else begin
      h_sel = {2'b0, r_size};
    end
    dbox     = $signed({1'b0, mag}) - $signed({2'b0, h_sel});
    comp_val = (prim == PRIM_SPH) ? mag
             : ((dbox > 0) ? dbox[COMP_W-1:0] : '0);
  end

  // Coarse mode when any magnitude reaches 2^31
  logic coarse_w;
  always_comb begin
    coarse_w = (|comp[0][COMP_W-1:31]) | (|comp[1][COMP_W-1:31]) |
               (|comp[2][COMP_W-1:31]);
  end

  // Box fully inside: distance is the largest excess
  logic box_in;
  always_comb begin
    box_in = (prim != PRIM_SPH) && (dmax <= 0);
  end

  // Primitive distance, saturated
  logic signed [POS_W-1:0] prim_val;
  logic signed [LEN_W:0]   sph_raw;
  always_comb begin
    sph_raw = $signed({1'b0, len_r}) - $signed({(LEN_W-SIZE_W+1)'(0), r_size});
    if (box_in) begin
      prim_val = (dmax < -DIFF_W'(DIST_MAX)) ? -DIST_MAX : dmax[POS_W-1:0];
    end else if (prim == PRIM_SPH) begin
      if (sph_raw > (LEN_W+1)'(DIST_MAX))        prim_val = DIST_MAX;
      else if (sph_raw < -(LEN_W+1)'(DIST_MAX))  prim_val = -DIST_MAX;
      else                                       prim_val = sph_raw[POS_W-1:0];
    end else begin
      prim_val = (len_r > LEN_W'(DIST_MAX)) ? DIST_MAX : len_r[POS_W-1:0];
    end
  end

  // Scene: union of box and sphere, minus cut box
  logic signed [POS_W-1:0] uni, cutn, scene;
  logic                    is_hit, is_esc;
  always_comb begin
    uni    = (prim_dist[0] < prim_dist[1]) ? prim_dist[0] : prim_dist[1];
    cutn   = -prim_dist[2];
    scene  = (uni > cutn) ? uni : cutn;
    is_hit = scene < $signed({1'b0, hit_dist});
    is_esc = scene > $signed({1'b0, esc_dist});
  end

  // Position advance with saturation
  logic signed [STEP_PROD_W-1:0] adv;
  logic signed [STEP_PROD_W:0]   np;
  logic signed [POS_W-1:0]       np_sat;
  always_comb begin
    adv = prod[PROD_W-1:DIR_FRAC];
    np  = (STEP_PROD_W+1)'(p[axis]) + (STEP_PROD_W+1)'(adv);
    if (np > (STEP_PROD_W+1)'(DIST_MAX))             np_sat = DIST_MAX;
    else if (np < -(STEP_PROD_W+1)'(DIST_MAX) - 1)   np_sat = -DIST_MAX - 1;
    else                                             np_sat = np[POS_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (ray.valid) state_next = S_CHECK;
      S_CHECK:  state_next = (step_cnt >= n_lim) ? S_DONE : S_COMP;
      S_COMP:   if (axis == 2'd2) state_next = S_PRIM;
      S_PRIM:   state_next = box_in ? S_STORE : S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (axis == 2'd2) ? S_SQS : S_MUL;
      S_SQS:    state_next = S_SQRT;
      S_SQRT:   if (sq_stat.done) state_next = S_STORE;
      S_STORE:  state_next = (prim == PRIM_CUT) ? S_DECIDE : S_COMP;
      S_DECIDE: state_next = (is_hit || is_esc) ? S_DONE : S_AMUL;
      S_AMUL:   state_next = S_AADD;
      S_AADD:   state_next = (axis == 2'd2) ? S_CHECK : S_AMUL;
      S_DONE:   if (!out_valid || res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Unit controls
  logic [MUL_W-1:0] sq_op;
  always_comb begin
    ray.ready  = (state == S_IDLE);
    sqrt_start = (state == S_SQS);
    sq_op = coarse ? MUL_W'(comp[axis][COMP_W-1:4]) : MUL_W'(comp[axis][30:0]);
    case (state)
      S_MUL: begin
        mul_a = $signed(sq_op);
        mul_b = $signed(sq_op);
      end
      S_AMUL: begin
        mul_a = MUL_W'(dir[axis]);
        mul_b = MUL_W'(scene_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      cz       <= '0;
      r_size   <= SIZE_RST;
      hit_dist <= HIT_RST;
      esc_dist <= ESCAPE_RST;
      steps    <= STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CX:     cx       <= cfg_wdata[POS_W-1:0];
        REG_CY:     cy       <= cfg_wdata[POS_W-1:0];
        REG_CZ:     cz       <= cfg_wdata[POS_W-1:0];
        REG_SIZE:   r_size   <= cfg_wdata[SIZE_W-1:0];
        REG_HIT:    hit_dist <= cfg_wdata[SIZE_W-1:0];
        REG_ESCAPE: esc_dist <= cfg_wdata[SIZE_W-1:0];
        REG_STEPS:  steps    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      prim      <= PRIM_BOX;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Result register: load when free or draining, else clear on take
      if (state == S_DONE && (!out_valid || res.ready)) out_valid <= 1'b1;
      else if (res.ready)                                out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          step_cnt <= '0;
        end
        S_CHECK: begin
          prim <= PRIM_BOX;
          axis <= '0;
        end
        S_COMP: axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
        S_ACC:  axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
        S_STORE: begin
          prim <= prim + 1'b1;
          axis <= '0;
        end
        S_DECIDE: begin
          step_cnt <= step_cnt + 1'b1;
          axis     <= '0;
        end
        S_AADD: axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p[0]   <= ray.origin_x;
        p[1]   <= ray.origin_y;
        p[2]   <= ray.origin_z;
        dir[0] <= ray.dir_x;
        dir[1] <= ray.dir_y;
        dir[2] <= ray.dir_z;
        hit_r  <= 1'b0;
      end
      S_COMP: begin
        comp[axis] <= comp_val;
        if (axis == 2'd0 || dbox > dmax) dmax <= dbox;
      end
      S_PRIM: begin
        coarse <= coarse_w;
        acc    <= '0;
      end
      S_ACC:  acc <= acc + RAD_W'(prod);
      S_SQRT: if (sq_stat.done) len_r <= coarse ? {root, 4'b0} : {4'b0, root};
      S_STORE: prim_dist[prim] <= prim_val;
      S_DECIDE: begin
        scene_r <= scene;
        hit_r   <= is_hit;
      end
      S_AADD: p[axis] <= np_sat;
      S_DONE: if (!out_valid || res.ready) out_hit <= hit_r;
      default: ;
    endcase
  end

  always_comb begin
    res.valid = out_valid;
    res.hit   = out_hit;
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    ray.valid && ray.ready |=> state == S_CHECK)
    else $error("accepted ray did not start a march");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sq_stat.busy)
    else $error("square root restarted while busy");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis != 2'd3)
    else $error("axis index out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> step_cnt <= n_lim)
    else $error("step count passed the limit");

  a_adv_nonneg: assert property (@(posedge clk) disable iff (rst)
    state == S_AMUL |-> !scene_r[POS_W-1])
    else $error("advance by a negative distance");

endmodule

`default_nettype wire

// File: sim/sdf_hit_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sdf_hit_checker
// Watches the ray and hit channels and the register port, predicts the hit
// flag of every accepted ray by marching it through the scene, and compares
// each returned flag against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_hit_checker
  import sdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  sdf_ray_if                         ray,
  sdf_hit_if                         res,
  output int                         errors,
  output int                         pending,
  output int                         hits_seen
);

  localparam longint unsigned COARSE_LIM = 64'd1 << 31;
  localparam longint unsigned COARSE_CAP = (64'd1 << 35) - 64'd1;
  localparam longint          SAT        = 64'd2147483647;
  localparam longint          POS_MIN    = -64'sd2147483648;

  // Mirrored register copy
  longint ctr_x, ctr_y, ctr_z;
  longint obj_size, hit_thr, esc_thr;
  int     step_cap;

  bit hit_expected_q[$];

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned acc, b;
    acc = 0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= acc + b) begin
        x   = x - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Euclidean length, rescaled by 16 when a component is large
  function automatic longint length3(longint unsigned a, longint unsigned b,
                                     longint unsigned c);
    if (a < COARSE_LIM && b < COARSE_LIM && c < COARSE_LIM)
      return longint'(root64(a * a + b * b + c * c));
    a = ((a > COARSE_CAP) ? COARSE_CAP : a) >> 4;
    b = ((b > COARSE_CAP) ? COARSE_CAP : b) >> 4;
    c = ((c > COARSE_CAP) ? COARSE_CAP : c) >> 4;
    return longint'(root64(a * a + b * b + c * c) << 4);
  endfunction

  function automatic longint sat_dist(longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint box_sdf(longint px, longint py, longint pz,
                                     longint cx, longint cy, longint cz,
                                     longint hx, longint hy, longint hz);
    longint dx, dy, dz, worst;
    dx = longint'(mag(px - cx)) - hx;
    dy = longint'(mag(py - cy)) - hy;
    dz = longint'(mag(pz - cz)) - hz;
    worst = dx;
    if (dy > worst) worst = dy;
    if (dz > worst) worst = dz;
    if (worst > 0)
      worst = length3((dx > 0) ? dx : 0, (dy > 0) ? dy : 0, (dz > 0) ? dz : 0);
    return sat_dist(worst);
  endfunction

  // Union of box and sphere, minus the cutting box
  function automatic longint scene_sdf(longint px, longint py, longint pz);
    longint a, b, cut, u;
    a = box_sdf(px, py, pz, ctr_x, ctr_y, ctr_z, obj_size, obj_size, obj_size);
    b = sat_dist(length3(mag(px - ctr_x), mag(py - ctr_y),
                         mag(pz - (ctr_z + longint'(OFF_SPH)))) - obj_size);
    cut = -box_sdf(px, py, pz, ctr_x, ctr_y, ctr_z + longint'(OFF_CUT),
                   obj_size * 2, obj_size * 2, obj_size >>> 1);
    u = (a < b) ? a : b;
    return (u > cut) ? u : cut;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > SAT) return SAT;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic bit march_hit(longint px, longint py, longint pz,
                                   longint dx, longint dy, longint dz);
    longint d;
    int n;
    n = (step_cap > MAX_STEPS) ? MAX_STEPS : step_cap;
    for (int s = 0; s < n; s++) begin
      d = scene_sdf(px, py, pz);
      if (d < hit_thr) return 1'b1;
      if (d > esc_thr) return 1'b0;
      px = clamp_pos(px + ((dx * d) >>> DIR_FRAC));
      py = clamp_pos(py + ((dy * d) >>> DIR_FRAC));
      pz = clamp_pos(pz + ((dz * d) >>> DIR_FRAC));
    end
    return 1'b0;
  endfunction

  initial begin
    errors    = 0;
    pending   = 0;
    hits_seen = 0;
  end

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      ctr_x    = 0;
      ctr_y    = 0;
      ctr_z    = 0;
      obj_size = SIZE_RST;
      hit_thr  = HIT_RST;
      esc_thr  = ESCAPE_RST;
      step_cap = STEPS_RST;
    end else begin
      // Register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_CX:     ctr_x = longint'(signed'(cfg_wdata));
          REG_CY:     ctr_y = longint'(signed'(cfg_wdata));
          REG_CZ:     ctr_z = longint'(signed'(cfg_wdata));
          REG_SIZE:   obj_size = cfg_wdata[SIZE_W-1:0];
          REG_HIT:    hit_thr = cfg_wdata[SIZE_W-1:0];
          REG_ESCAPE: esc_thr = cfg_wdata[SIZE_W-1:0];
          REG_STEPS:  step_cap = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      // Accepted ray request: predict
      if (ray.valid && ray.ready)
        hit_expected_q.push_back(march_hit(ray.origin_x, ray.origin_y, ray.origin_z,
                                           ray.dir_x, ray.dir_y, ray.dir_z));
      // Accepted result: compare
      if (res.valid && res.ready) begin
        if (res.hit) hits_seen++;
        if (hit_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result hit=%0b", $realtime, res.hit);
        end else begin
          want = hit_expected_q.pop_front();
          if (want !== res.hit) begin
            errors++;
            if (errors <= 10)
              $display("%0t: hit mismatch: expected %0b got %0b", $realtime, want, res.hit);
          end
        end
      end
    end
    pending = hit_expected_q.size();
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Ray march hit test bench: directed rays, then register phases of aimed,
// scattered and random rays with random stalls on both channels (but for the
// closing phase); the checker predicts every hit flag.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import sdf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;   // no register here
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 1500;
  localparam longint ONE        = 65536;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors, pending, hits_seen;
  int                    rays_sent;
  int                    idle_cycles;
  bit                    calm;
  bit                    hold_req;

  // Stimulus copy of the scene placement, used for aiming only
  longint aim_cx, aim_cy, aim_cz, aim_size;

  sdf_ray_if ray_ch ();
  sdf_hit_if hit_ch ();

  sdf_ray_march_hit_test dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ray       (ray_ch),
    .res       (hit_ch)
  );

  sdf_hit_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ray       (ray_ch),
    .res       (hit_ch),
    .errors    (errors),
    .pending   (pending),
    .hits_seen (hits_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles with no request accepted on either channel
  always @(posedge clk) begin
    if (rst || (ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int held;
    hit_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hit_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        hit_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_ray(longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= ox[31:0];
    ray_ch.origin_y <= oy[31:0];
    ray_ch.origin_z <= oz[31:0];
    ray_ch.dir_x    <= dx[17:0];
    ray_ch.dir_y    <= dy[17:0];
    ray_ch.dir_z    <= dz[17:0];
    do @(posedge clk); while (!ray_ch.ready);
    rays_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      ray_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_dir(real v);
    longint q;
    q = longint'(v * 65536.0) + $signed($urandom_range(0, 2000)) - 1000;
    if (q > 65536) q = 65536;
    if (q < -65536) q = -65536;
    return q;
  endfunction

  // One random ray: mostly aimed at the scene, some scattered, some noise
  task automatic random_ray();
    longint span, ox, oy, oz, tz;
    real    vx, vy, vz, len;
    int     kind;
    kind = $urandom_range(0, 9);
    span = aim_size * 6 + ONE;
    if (span > 64'sd1073741824) span = 64'sd1073741824;
    if (kind >= 8) begin
      send_ray(longint'($urandom), longint'($urandom), longint'($urandom),
               longint'($urandom), longint'($urandom), longint'($urandom));
    end else begin
      ox = aim_cx + longint'($urandom_range(0, 2000)) * span / 1000 - span;
      oy = aim_cy + longint'($urandom_range(0, 2000)) * span / 1000 - span;
      oz = aim_cz + longint'($urandom_range(0, 2000)) * span / 1000 - span;
      if (kind >= 6) begin
        vx = $signed($urandom_range(0, 2000)) - 1000;
        vy = $signed($urandom_range(0, 2000)) - 1000;
        vz = $signed($urandom_range(0, 2000)) - 1000;
      end else begin
        tz = aim_cz + longint'($urandom_range(0, 157286));
        vx = real'(aim_cx - ox);
        vy = real'(aim_cy - oy);
        vz = real'(tz - oz);
      end
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      if (len == 0.0) begin
        vz  = 1.0;
        len = 1.0;
      end
      send_ray(sat32(ox), sat32(oy), sat32(oz),
               to_dir(vx / len), to_dir(vy / len), to_dir(vz / len));
    end
  endtask

  // Wait until every request has its result, with the block idle
  task automatic drain();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(longint cx, longint cy, longint cz, longint size,
                            longint hit, longint esc, int steps);
    logic [CFG_DATA_W-1:0] vals[8];
    vals[REG_CX]     = cx[31:0];
    vals[REG_CY]     = cy[31:0];
    vals[REG_CZ]     = cz[31:0];
    vals[REG_SIZE]   = size[31:0];
    vals[REG_HIT]    = hit[31:0];
    vals[REG_ESCAPE] = esc[31:0];
    vals[REG_STEPS]  = steps;
    vals[REG_SPARE]  = $urandom;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    aim_cx   = cx;
    aim_cy   = cy;
    aim_cz   = cz;
    aim_size = size;
  endtask

  task automatic random_phase(int count);
    repeat (count) random_ray();
    drain();
  endtask

  // Stimulus
  initial begin
    rays_sent       = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    idle_cycles     = 0;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    ray_ch.valid    <= 1'b0;
    ray_ch.origin_x <= '0;
    ray_ch.origin_y <= '0;
    ray_ch.origin_z <= '0;
    ray_ch.dir_x    <= '0;
    ray_ch.dir_y    <= '0;
    ray_ch.dir_z    <= '0;
    aim_cx = 0; aim_cy = 0; aim_cz = 0; aim_size = ONE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays under reset registers
    send_ray(0, 0, -5 * ONE, 0, 0, 65536);                       // straight hit from below
    send_ray(0, 0, 0, 0, 0, 65536);                              // starts inside
    send_ray(5 * ONE, 0, 0, -65536, 0, 0);
    send_ray(0, -5 * ONE, 0, 0, 65536, 0);
    send_ray(0, 0, -5 * ONE, 0, 0, -65536);                      // pointing away
    send_ray(0, 0, 10 * ONE, 0, 0, -65536);                      // through the cut
    send_ray(0, 0, 3 * ONE / 2, 0, 0, 65536);                    // inside sphere, cut above
    send_ray(3 * ONE, 0, 0, 0, 0, 0);                            // zero direction
    send_ray(100 * ONE, 0, 0, -65536, 0, 0);                     // escapes at once
    send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 65536, 65536, 65536);
    send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, -65536, -65536, -65536);
    send_ray(3 * ONE, 3 * ONE, 3 * ONE, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff);
    send_ray(-3 * ONE, -3 * ONE, -3 * ONE, 18'sh20000, 18'sh20000, 18'sh20000);
    send_ray(2 * ONE, 0, -2 * ONE, -46341, 0, 46341);
    send_ray(0, 0, 49 * ONE, 0, 0, -65536);                      // near escape bound
    send_ray(ONE + 3000, 0, 0, -65536, 0, 0);                    // just outside the face
    send_ray(0, 2 * ONE, 17 * ONE / 10, 0, -65536, 0);           // sphere side
    send_ray(0, 0, -7 * ONE, 1000, -1000, 65000);
    drain();

    // Defaults, with one long hold-off on the result side
    hold_req = 1'b1;
    random_phase(200);

    // Moderate random placement
    write_regs($signed($urandom_range(0, 2000000)) - 1000000,
               $signed($urandom_range(0, 2000000)) - 1000000,
               $signed($urandom_range(0, 2000000)) - 1000000,
               $urandom_range(20000, 200000), 3277, 3276800, 8);
    random_phase(250);

    // Upper extremes: huge scene, never hits until inside
    write_regs(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
               64'sd2147483647, 0, 64'sd2147483647, 63);
    random_phase(12);

    // Lower extremes: point scene, every ray hits or escapes at once
    write_regs(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
               0, 64'sd2147483647, 0, 1);
    random_phase(150);

    // No march steps at all
    write_regs(0, 0, 0, ONE, 3277, 3276800, 0);
    random_phase(40);

    // Tight thresholds, long marches
    write_regs($signed($urandom_range(0, 400000)) - 200000, 0, 0,
               2 * ONE, 65, 20 * ONE, 20);
    random_phase(150);

    // Closing stretch without idling
    write_regs(0, ONE, -ONE, ONE, 6000, 3276800, 6);
    calm = 1'b1;
    random_phase(280);

    repeat (200) @(posedge clk);
    $display("Sent %0d rays over seven register settings; %0d came back as hits.",
             rays_sent, hits_seen);
    $display("Covered step limits 0 to 63, extreme placements, stalls and a long hold-off.");
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
